[hw/rtl/ccst_pkg.sv]
// Shared types, codes and defaults for the client capability slot table.
package ccst_pkg;

    localparam int MAX_CLIENTS_DEF     = 16;
    localparam int CAPS_PER_CLIENT_DEF = 16;
    localparam int BADGE_W             = 32;
    localparam int CAP_W               = 32;
    localparam int STATUS_W            = 2;
    localparam int SLOT_W              = 4;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // Operation codes
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_LOOKUP   = 1'b1;

    // Result codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_NO_ENTRY  = 2'd2;
    localparam status_t ST_LIST_FULL = 2'd3;

    typedef struct packed {
        logic                    mode;
        logic [BADGE_W-1:0]      badge;
        logic signed [CAP_W-1:0] cap;
    } req_t;

    typedef struct packed {
        status_t status;
        slot_t   slot;
    } rsp_t;

endpackage

[hw/rtl/ccst_chan_if.sv]
// Valid/ready channel carrying one payload word.
interface ccst_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/client_capability_slot_table.sv]
// Client capability slot table: client badge table and per-client capability lists.
// A request first scans the client entries against its badge, if there are any (one client
//   table read per cycle); a register request then writes in the hit or miss state, and a
//   lookup of a known client also compares its slots (one capability read per cycle).
// One word at a time: the next word is taken once the result is in the output register,
//   which holds it.
// Reset: the client count and all control clear at once; no clearing pass is needed.
module client_capability_slot_table #(
    parameter int MAX_CLIENTS     = ccst_pkg::MAX_CLIENTS_DEF,
    parameter int CAPS_PER_CLIENT = ccst_pkg::CAPS_PER_CLIENT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ccst_chan_if.sink   req,
    ccst_chan_if.source rsp
);

    localparam int EW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW    = $clog2(MAX_CLIENTS + 1);
    localparam int SW    = (CAPS_PER_CLIENT > 1) ? $clog2(CAPS_PER_CLIENT) : 1;
    localparam int FW    = $clog2(CAPS_PER_CLIENT + 1);
    localparam int TBL_W = ccst_pkg::BADGE_W + FW;
    localparam int CAP_DEPTH = MAX_CLIENTS << SW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Memories: client table {badge, fill} and capability rows
    logic [TBL_W-1:0]             tbl_mem [MAX_CLIENTS];
    logic [ccst_pkg::CAP_W-1:0]   cap_mem [CAP_DEPTH];

    logic [TBL_W-1:0]             tbl_rdata_reg;
    logic [ccst_pkg::CAP_W-1:0]   cap_rdata_reg;

    logic [EW-1:0]                tbl_raddr;
    logic                         tbl_we;
    logic [EW-1:0]                tbl_waddr;
    logic [TBL_W-1:0]             tbl_wdata;
    logic [EW+SW-1:0]             cap_raddr;
    logic                         cap_we;
    logic [EW+SW-1:0]             cap_waddr;

    // Control registers
    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [FW-1:0]   slot_idx_reg, slot_idx_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic                         mode_reg;
    logic [ccst_pkg::BADGE_W-1:0] badge_reg;
    logic [ccst_pkg::CAP_W-1:0]   cap_reg;
    logic [EW-1:0]                entry_reg, entry_next;
    logic [FW-1:0]                fill_reg, fill_next;
    ccst_pkg::status_t            res_status_reg, res_status_next;
    ccst_pkg::slot_t              res_slot_reg, res_slot_next;
    ccst_pkg::rsp_t               out_reg;

    logic                         accept;
    logic                         out_free;
    logic [ccst_pkg::BADGE_W-1:0] rd_badge;
    logic [FW-1:0]                rd_fill;
    logic [CW-1:0]                idx_inc;
    logic [FW-1:0]                slot_inc;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign rd_badge = tbl_rdata_reg[TBL_W-1:FW];
    assign rd_fill  = tbl_rdata_reg[FW-1:0];
    assign idx_inc  = idx_reg + CW'(1);
    assign slot_inc = slot_idx_reg + FW'(1);

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Sequence the scan, the update and the hand-off
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        slot_idx_next   = slot_idx_reg;
        entry_next      = entry_reg;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        tbl_raddr       = idx_reg[EW-1:0];
        tbl_we          = 1'b0;
        tbl_waddr       = entry_reg;
        tbl_wdata       = {badge_reg, fill_reg + FW'(1)};
        cap_raddr       = {entry_reg, slot_idx_reg[SW-1:0]};
        cap_we          = 1'b0;
        cap_waddr       = {entry_reg, fill_reg[SW-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                tbl_raddr = '0;
                idx_next  = '0;
                if (accept)
                begin
                    state_next = (cnt_reg == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_badge == badge_reg)
                begin
                    entry_next = idx_reg[EW-1:0];
                    fill_next  = rd_fill;
                    state_next = S_HIT;
                end
                else if (idx_inc == cnt_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next  = idx_inc;
                    tbl_raddr = idx_inc[EW-1:0];
                end
            end
            S_HIT:
            begin
                slot_idx_next = '0;
                cap_raddr     = {entry_reg, {SW{1'b0}}};
                if (mode_reg == ccst_pkg::MODE_REGISTER)
                begin
                    state_next = S_DONE;
                    if (fill_reg >= FW'(CAPS_PER_CLIENT))
                    begin
                        res_status_next = ccst_pkg::ST_LIST_FULL;
                        res_slot_next   = '0;
                    end
                    else
                    begin
                        tbl_we          = 1'b1;
                        cap_we          = 1'b1;
                        res_status_next = ccst_pkg::ST_OK;
                        res_slot_next   = ccst_pkg::slot_t'(fill_reg);
                    end
                end
                else if (fill_reg == '0)
                begin
                    res_status_next = ccst_pkg::ST_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end
            S_MISS:
            begin
                state_next    = S_DONE;
                res_slot_next = '0;
                if (mode_reg == ccst_pkg::MODE_LOOKUP)
                begin
                    res_status_next = ccst_pkg::ST_NOT_FOUND;
                end
                else if (cnt_reg == CW'(MAX_CLIENTS))
                begin
                    res_status_next = ccst_pkg::ST_NO_ENTRY;
                end
                else
                begin
                    // Open the lowest free entry with the word at slot zero
                    tbl_we          = 1'b1;
                    tbl_waddr       = cnt_reg[EW-1:0];
                    tbl_wdata       = {badge_reg, FW'(1)};
                    cap_we          = 1'b1;
                    cap_waddr       = {cnt_reg[EW-1:0], {SW{1'b0}}};
                    cnt_next        = cnt_reg + CW'(1);
                    res_status_next = ccst_pkg::ST_OK;
                end
            end
            S_LOOK:
            begin
                if (cap_rdata_reg == cap_reg)
                begin
                    res_status_next = ccst_pkg::ST_OK;
                    res_slot_next   = ccst_pkg::slot_t'(slot_idx_reg);
                    state_next      = S_DONE;
                end
                else if (slot_inc == fill_reg)
                begin
                    res_status_next = ccst_pkg::ST_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    slot_idx_next = slot_inc;
                    cap_raddr     = {entry_reg, slot_inc[SW-1:0]};
                end
            end
            S_DONE:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            slot_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            slot_idx_reg  <= slot_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request word and working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.payload.mode;
            badge_reg <= req.payload.badge;
            cap_reg   <= req.payload.cap;
        end
        entry_reg      <= entry_next;
        fill_reg       <= fill_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_reg.status <= res_status_reg;
            out_reg.slot   <= res_slot_reg;
        end
    end

    // Client table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // Capability memory
    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[cap_waddr] <= cap_reg;
        end
        cap_rdata_reg <= cap_mem[cap_raddr];
    end

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_CLIENTS))
        else $error("client count beyond table size");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN || state_reg == S_MISS))
        else $error("accepted word did not start a scan");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside hand-off");

    a_slot_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ccst_pkg::ST_OK || out_reg.slot == '0))
        else $error("nonzero slot with error status");

    a_look_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> (slot_idx_reg < fill_reg))
        else $error("slot search past list fill");

endmodule

[tb/tb_client_capability_slot_table.sv]
// Testbench for the client capability slot table: directed rows, then random words.
module tb_client_capability_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CLIENTS    = ccst_pkg::MAX_CLIENTS_DEF;
    localparam int N_SLOTS      = ccst_pkg::CAPS_PER_CLIENT_DEF;
    localparam int RANDOM_WORDS = 1225;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 50;
    localparam int N_BADGES     = 20;
    localparam int N_CAPS       = 12;

    // One directed row; reps > 1 repeats the row with cap stepping up by one
    typedef struct packed {
        logic              mode;
        logic [31:0]       badge;
        logic [31:0]       cap;
        int                reps;
        logic              typed;
        ccst_pkg::status_t status;
        ccst_pkg::slot_t   slot;
    } stim_row_t;

    localparam int N_ROWS = 12;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        // empty table after reset
        '{ccst_pkg::MODE_LOOKUP,   32'h0000_0000, 32'h0000_0000,  1,
          1'b1, ccst_pkg::ST_NOT_FOUND, 4'd0},
        // extreme badge, extreme caps
        '{ccst_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF,  1,
          1'b1, ccst_pkg::ST_OK,        4'd0},
        '{ccst_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'h8000_0000,  1,
          1'b1, ccst_pkg::ST_OK,        4'd1},
        '{ccst_pkg::MODE_LOOKUP,   32'hFFFF_FFFF, 32'h8000_0000,  1,
          1'b1, ccst_pkg::ST_OK,        4'd1},
        '{ccst_pkg::MODE_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000,  1,
          1'b1, ccst_pkg::ST_NOT_FOUND, 4'd0},
        // second client, duplicate capability, first slot wins
        '{ccst_pkg::MODE_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF,  1,
          1'b1, ccst_pkg::ST_OK,        4'd0},
        '{ccst_pkg::MODE_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF,  1,
          1'b0, ccst_pkg::ST_OK,        4'd0},
        '{ccst_pkg::MODE_LOOKUP,   32'h0000_0000, 32'hFFFF_FFFF,  1,
          1'b1, ccst_pkg::ST_OK,        4'd0},
        // unknown client
        '{ccst_pkg::MODE_LOOKUP,   32'h1234_5678, 32'h7FFF_FFFF,  1,
          1'b1, ccst_pkg::ST_NOT_FOUND, 4'd0},
        // fill the list, then overflow it, then find the top slot
        '{ccst_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'h0000_1000, 14,
          1'b0, ccst_pkg::ST_OK,        4'd0},
        '{ccst_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'h0000_0005,  1,
          1'b1, ccst_pkg::ST_LIST_FULL, 4'd0},
        '{ccst_pkg::MODE_LOOKUP,   32'hFFFF_FFFF, 32'h0000_100D,  1,
          1'b1, ccst_pkg::ST_OK,        4'd15}
    };

    logic clk = 1'b0;
    logic rst_n;

    ccst_chan_if #(.payload_t(ccst_pkg::req_t)) req_if ();
    ccst_chan_if #(.payload_t(ccst_pkg::rsp_t)) rsp_if ();

    client_capability_slot_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    // Shadow copy of the client table
    logic              client_used [N_CLIENTS];
    logic [31:0]       shadow_badge [N_CLIENTS];
    int                client_count [N_CLIENTS];
    logic [31:0]       client_caps [N_CLIENTS][N_SLOTS];

    ccst_pkg::rsp_t    pending_results [$];
    int                n_errors = 0;
    int                idle_cycles = 0;
    logic [31:0]       badge_pool [N_BADGES];
    logic [31:0]       cap_pool [N_CAPS];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // Gap before the next word; every fifth stretch of 48 runs with no idling
    function automatic int draw_gap(input int idx);
        if ((idx / 48) % 5 == 4)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Apply one request to the shadow table and return the slot status it gives
    function automatic ccst_pkg::rsp_t apply_request(input ccst_pkg::req_t w);
        int             hit;
        int             free_ix;
        int             i;
        ccst_pkg::rsp_t r;
        hit = -1;
        free_ix = -1;
        for (i = 0; i < N_CLIENTS; i++)
        begin
            if (hit < 0 && client_used[i] && shadow_badge[i] == w.badge)
                hit = i;
            if (free_ix < 0 && !client_used[i])
                free_ix = i;
        end
        r.status = ccst_pkg::ST_NOT_FOUND;
        r.slot = '0;
        if (w.mode == ccst_pkg::MODE_REGISTER)
        begin
            if (hit >= 0)
            begin
                if (client_count[hit] >= N_SLOTS)
                    r.status = ccst_pkg::ST_LIST_FULL;
                else
                begin
                    client_caps[hit][client_count[hit]] = w.cap;
                    r.status = ccst_pkg::ST_OK;
                    r.slot = ccst_pkg::slot_t'(client_count[hit]);
                    client_count[hit]++;
                end
            end
            else if (free_ix < 0)
                r.status = ccst_pkg::ST_NO_ENTRY;
            else
            begin
                client_used[free_ix] = 1'b1;
                shadow_badge[free_ix] = w.badge;
                for (i = 0; i < N_SLOTS; i++)
                    client_caps[free_ix][i] = '0;
                client_caps[free_ix][0] = w.cap;
                client_count[free_ix] = 1;
                r.status = ccst_pkg::ST_OK;
            end
        end
        else if (hit >= 0)
        begin
            for (i = client_count[hit] - 1; i >= 0; i--)
            begin
                if (client_caps[hit][i] == w.cap)
                begin
                    r.status = ccst_pkg::ST_OK;
                    r.slot = ccst_pkg::slot_t'(i);
                end
            end
        end
        return r;
    endfunction

    // Offer one word after a gap, hold it until taken, then record its result
    task automatic send_word(input ccst_pkg::req_t w, input int gap, input logic typed,
                             input ccst_pkg::rsp_t typed_result);
        ccst_pkg::rsp_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_request(w);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Sender: reset, directed rows, random words, drain
    initial
    begin
        int             idx;
        int             r;
        int             k;
        int             n;
        ccst_pkg::req_t w;
        stim_row_t      row;
        ccst_pkg::rsp_t typed_result;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        for (k = 0; k < N_CLIENTS; k++)
        begin
            client_used[k] = 1'b0;
            shadow_badge[k] = '0;
            client_count[k] = 0;
            for (n = 0; n < N_SLOTS; n++)
                client_caps[k][n] = '0;
        end
        badge_pool[0] = 32'h0000_0000;
        badge_pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < N_BADGES; k++)
            badge_pool[k] = $urandom;
        cap_pool[0] = 32'h0000_0000;
        cap_pool[1] = 32'hFFFF_FFFF;
        cap_pool[2] = 32'h7FFF_FFFF;
        cap_pool[3] = 32'h8000_0000;
        for (k = 4; k < N_CAPS; k++)
            cap_pool[k] = $urandom;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        idx = 0;
        for (r = 0; r < N_ROWS; r++)
        begin
            row = DIRECTED[r];
            for (k = 0; k < row.reps; k++)
            begin
                w.mode = row.mode;
                w.badge = row.badge;
                w.cap = row.cap + k;
                typed_result.status = row.status;
                typed_result.slot = row.slot;
                send_word(w, draw_gap(idx), row.typed, typed_result);
                idx++;
            end
        end

        // Registers stay on the badge pool; lookups sometimes ask a stranger
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            w.mode = ($urandom_range(0, 9) < 4) ? ccst_pkg::MODE_REGISTER
                                                : ccst_pkg::MODE_LOOKUP;
            if (w.mode == ccst_pkg::MODE_LOOKUP && $urandom_range(0, 9) == 0)
                w.badge = $urandom;
            else
                w.badge = badge_pool[$urandom_range(0, N_BADGES - 1)];
            if ($urandom_range(0, 3) == 0)
                w.cap = $urandom;
            else
                w.cap = cap_pool[$urandom_range(0, N_CAPS - 1)];
            send_word(w, draw_gap(idx), 1'b0, '0);
            idx++;
        end
        @(negedge clk);
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("client_capability_slot_table: match");
        else
            $display("client_capability_slot_table: mismatch");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, compare each word
    initial
    begin
        int             n_seen;
        int             gap;
        ccst_pkg::rsp_t got;
        ccst_pkg::rsp_t want;
        rsp_if.ready = 1'b0;
        n_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (n_seen == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(n_seen);
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid)
                @(posedge clk);
            got = rsp_if.payload;
            n_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("word %0d with nothing pending: status %0d slot %0d",
                                          n_seen, got.status, got.slot));
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("word %0d status %0d, predicted %0d",
                                              n_seen, got.status, want.status));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("word %0d slot %0d, predicted %0d",
                                              n_seen, got.slot, want.slot));
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("client_capability_slot_table: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

[files.f]
hw/rtl/ccst_pkg.sv
hw/rtl/ccst_chan_if.sv
hw/rtl/client_capability_slot_table.sv
tb/tb_client_capability_slot_table.sv
